/* rtl/core/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, register codes, reset values and request type of the disk
// seek scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int CYL_W   = 12;
	localparam int SUM_W   = 18;
	localparam int MODE_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam int MAX_REQ_DEF = 16;

	// scheduling modes
	localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_UP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP      = 2'd3;

	// register reset values
	localparam logic [MODE_W-1:0] RST_MODE     = MODE_FCFS;
	localparam logic [CYL_W-1:0]  RST_START    = 12'd50;
	localparam logic              RST_START_UP = 1'b1;
	localparam logic [CYL_W-1:0]  RST_TOP      = 12'd99;

	typedef struct packed {
		logic [CYL_W-1:0] cyl;
		logic             last;
	} req_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CYL_W-1:0]  start_cyl;
		logic              start_up;
		logic [CYL_W-1:0]  top_cyl;
	} cfg_t;

endpackage

/* rtl/core/dss_ram.sv */
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/dss_front.sv */
// ----------------------------------------------------------------------------
// dss_front
// Request intake: clamp each cylinder to the top cylinder and hold it in a
// two-entry queue for the scheduler.
// ----------------------------------------------------------------------------
module dss_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [dss_pkg::CYL_W-1:0] cylinder,
	input  logic                      last_request,
	input  logic [dss_pkg::CYL_W-1:0] top_cyl,
	output logic                      q_valid,
	output dss_pkg::req_t             q_req,
	input  logic                      q_pop
);

	dss_pkg::req_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          push;
	dss_pkg::req_t in_req;

	assign busy    = (fill_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_req   = entry_q[rd_ptr_q];

	always_comb begin
		in_req.cyl  = (cylinder > top_cyl) ? top_cyl : cylinder;
		in_req.last = last_request;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (q_pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/core/dss_back.sv */
// ----------------------------------------------------------------------------
// dss_back
// Scheduler: store the batch, then pick each next cylinder by a full scan of
// the store per visit and issue the results.
// ----------------------------------------------------------------------------
module dss_back #(
	parameter int MAX_REQ = dss_pkg::MAX_REQ_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  dss_pkg::req_t             q_req,
	output logic                      q_pop,
	input  dss_pkg::cfg_t             cfg,
	output logic                      res_strobe,
	output logic [dss_pkg::CYL_W-1:0] res_visited,
	output logic [dss_pkg::SUM_W-1:0] res_sum,
	output logic                      res_turn,
	output logic                      res_final
);

	localparam int IDX_W = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
	localparam int CNT_W = $clog2(MAX_REQ + 1);
	localparam int CYL_W = dss_pkg::CYL_W;
	localparam int SUM_W = dss_pkg::SUM_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIXED, ST_FINISH} state_t;
	typedef enum logic [2:0] {
		PH_FCFS, PH_SSTF, PH_UP, PH_DOWN, PH_LOWUP, PH_TOP, PH_ZEROS, PH_ZEROC
	} phase_t;

	function automatic logic [CYL_W-1:0] abs_diff(input logic [CYL_W-1:0] a,
	                                              input logic [CYL_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	state_t             state_q, nx_state;
	phase_t             phase_q, nx_phase, init_phase;
	logic [CNT_W-1:0]   cnt_q, ptr_q;
	logic               ev_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               found_q;
	logic [CYL_W-1:0]   bestv_q, bestd_q;
	logic [IDX_W-1:0]   besti_q;
	logic [MAX_REQ-1:0] served_q;
	logic [CYL_W-1:0]   arm_q;
	logic [SUM_W-1:0]   sum_q;
	logic               turns_q, turns_nx;
	logic               pend_q;
	logic [CYL_W-1:0]   pvis_q;
	logic [SUM_W-1:0]   psum_q;
	logic               pturn_q;
	logic               strobe_q, final_q;
	logic [CYL_W-1:0]   vis_q;
	logic [SUM_W-1:0]   osum_q;
	logic               oturn_q;

	logic               issue, we, exhausted, take, restart, mark;
	logic [IDX_W-1:0]   raddr;
	logic [CYL_W-1:0]   rd_v, cand_d;
	logic               mv_en, mv_turn, look_second;
	logic [CYL_W-1:0]   mv_tgt, mv_d;
	logic [SUM_W-1:0]   mv_sum;

	assign issue = (state_q == ST_SCAN) && (ptr_q < cnt_q);
	assign raddr = ptr_q[IDX_W-1:0];
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign we    = q_pop && (cnt_q < CNT_W'(MAX_REQ));

	dss_ram #(
		.WIDTH (CYL_W),
		.DEPTH (MAX_REQ),
		.AW    (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (q_req.cyl),
		.raddr (raddr),
		.rdata (rd_v)
	);

	assign cand_d    = abs_diff(rd_v, arm_q);
	assign exhausted = (state_q == ST_SCAN) && !issue && !ev_s1;
	assign look_second = (cfg.mode == dss_pkg::MODE_LOOK) &&
	                     ((phase_q == PH_UP) == !cfg.start_up);

	always_comb begin
		take = 1'b0;
		if (!served_q[idx_s1]) begin
			unique case (phase_q)
				PH_FCFS:  take = !found_q;
				PH_SSTF:  take = !found_q || (cand_d < bestd_q);
				PH_UP:    take = (rd_v >= cfg.start_cyl) && (!found_q || rd_v < bestv_q);
				PH_DOWN:  take = (rd_v < cfg.start_cyl) && (!found_q || rd_v > bestv_q);
				PH_LOWUP: take = (rd_v < cfg.start_cyl) && (!found_q || rd_v < bestv_q);
				default:  take = 1'b0;
			endcase
		end
	end

	always_comb begin
		unique case (cfg.mode)
			dss_pkg::MODE_SSTF:  init_phase = PH_SSTF;
			dss_pkg::MODE_SCAN:  init_phase = PH_UP;
			dss_pkg::MODE_CSCAN: init_phase = PH_UP;
			dss_pkg::MODE_LOOK:  init_phase = cfg.start_up ? PH_UP : PH_DOWN;
			default:             init_phase = PH_FCFS;
		endcase
	end

	// pick the move and the next phase once a scan or a fixed step completes
	always_comb begin
		mv_en    = 1'b0;
		mv_tgt   = bestv_q;
		mv_turn  = turns_q;
		turns_nx = turns_q;
		nx_phase = phase_q;
		nx_state = state_q;
		restart  = 1'b0;
		mark     = 1'b0;
		if (exhausted) begin
			if (found_q) begin
				mv_en = 1'b1;
				mark  = 1'b1;
				if (look_second) begin
					turns_nx = 1'b1;
				end
				mv_turn = turns_nx;
				restart = 1'b1;
			end else begin
				priority case (phase_q)
					PH_UP: begin
						if (cfg.mode == dss_pkg::MODE_SCAN || cfg.mode == dss_pkg::MODE_CSCAN) begin
							nx_phase = PH_TOP;
							nx_state = ST_FIXED;
						end else if (cfg.mode == dss_pkg::MODE_LOOK && cfg.start_up) begin
							nx_phase = PH_DOWN;
							restart  = 1'b1;
						end else begin
							nx_state = ST_FINISH;
						end
					end
					PH_DOWN: begin
						if (cfg.mode == dss_pkg::MODE_SCAN) begin
							nx_phase = PH_ZEROS;
							nx_state = ST_FIXED;
						end else if (cfg.mode == dss_pkg::MODE_LOOK && !cfg.start_up) begin
							nx_phase = PH_UP;
							restart  = 1'b1;
						end else begin
							nx_state = ST_FINISH;
						end
					end
					default: nx_state = ST_FINISH;
				endcase
			end
		end else if (state_q == ST_FIXED) begin
			priority case (phase_q)
				PH_TOP: begin
					mv_en    = (arm_q < cfg.top_cyl);
					mv_tgt   = cfg.top_cyl;
					turns_nx = 1'b1;
					if (cfg.mode == dss_pkg::MODE_SCAN) begin
						nx_phase = PH_DOWN;
						restart  = 1'b1;
					end else begin
						nx_phase = PH_ZEROC;
					end
				end
				PH_ZEROC: begin
					mv_en    = 1'b1;
					mv_tgt   = '0;
					nx_phase = PH_LOWUP;
					restart  = 1'b1;
				end
				default: begin
					mv_en    = (arm_q != '0);
					mv_tgt   = '0;
					nx_state = ST_FINISH;
				end
			endcase
		end
		if (restart) begin
			nx_state = ST_SCAN;
		end
	end

	assign mv_d   = abs_diff(mv_tgt, arm_q);
	assign mv_sum = sum_q + SUM_W'(mv_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_FCFS;
			cnt_q    <= '0;
			ptr_q    <= '0;
			ev_s1    <= 1'b0;
			found_q  <= 1'b0;
			served_q <= '0;
			turns_q  <= 1'b0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			ev_s1    <= issue;
			idx_s1   <= raddr;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (ev_s1 && take) begin
				found_q <= 1'b1;
				bestv_q <= rd_v;
				besti_q <= idx_s1;
				bestd_q <= cand_d;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (we) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (q_req.last) begin
							arm_q   <= cfg.start_cyl;
							sum_q   <= '0;
							turns_q <= 1'b0;
							found_q <= 1'b0;
							ptr_q   <= '0;
							phase_q <= init_phase;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN, ST_FIXED: begin
					if (exhausted || state_q == ST_FIXED) begin
						if (mv_en) begin
							arm_q <= mv_tgt;
							sum_q <= mv_sum;
							// hold one result back so the last one can be flagged
							if (pend_q) begin
								strobe_q <= 1'b1;
								final_q  <= 1'b0;
								vis_q    <= pvis_q;
								osum_q   <= psum_q;
								oturn_q  <= pturn_q;
							end
							pend_q  <= 1'b1;
							pvis_q  <= mv_tgt;
							psum_q  <= mv_sum;
							pturn_q <= mv_turn;
						end
						if (mark) begin
							served_q[besti_q] <= 1'b1;
						end
						turns_q <= turns_nx;
						phase_q <= nx_phase;
						state_q <= nx_state;
						if (restart) begin
							ptr_q   <= '0;
							found_q <= 1'b0;
						end
					end
				end
				ST_FINISH: begin
					if (pend_q) begin
						strobe_q <= 1'b1;
						final_q  <= 1'b1;
						vis_q    <= pvis_q;
						osum_q   <= psum_q;
						oturn_q  <= pturn_q;
					end
					pend_q   <= 1'b0;
					cnt_q    <= '0;
					served_q <= '0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_strobe  = strobe_q;
	assign res_visited = vis_q;
	assign res_sum     = osum_q;
	assign res_turn    = oturn_q;
	assign res_final   = final_q;

endmodule

/* rtl/core/disk_seek_scheduler_top.sv */
// ----------------------------------------------------------------------------
// disk_seek_scheduler_top
// Batch disk arm scheduler: FCFS, SSTF, SCAN, C-SCAN and LOOK service order.
// ----------------------------------------------------------------------------
// Requests enter one per cycle while busy is low through start/busy into a
// two-entry queue and are written into the request store one per cycle while
// no pass runs; busy rises only while that queue is full. The request flagged
// last_request starts a pass. For each visited cylinder the next pick scans
// the whole stored batch through the single read port of the request RAM;
// fixed sweep moves (top cylinder, cylinder 0) need no scan. Results appear
// on result_strobe for exactly one cycle each and cannot be stalled;
// final_step marks the last one of the pass. Requests for the next batch
// queue up while a pass runs. Write configuration only while no pass is
// running.
// ----------------------------------------------------------------------------
module disk_seek_scheduler_top #(
	parameter int MAX_REQUESTS = dss_pkg::MAX_REQ_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           start,
	output logic                           busy,
	input  logic [dss_pkg::CYL_W-1:0]      cylinder,
	input  logic                           last_request,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
	// results
	output logic                           result_strobe,
	output logic [dss_pkg::CYL_W-1:0]      visited,
	output logic [dss_pkg::SUM_W-1:0]      seek_total,
	output logic                           turn_count,
	output logic                           final_step
);

	dss_pkg::cfg_t cfg_q;
	logic          q_valid;
	dss_pkg::req_t q_req;
	logic          q_pop;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= dss_pkg::RST_MODE;
			cfg_q.start_cyl <= dss_pkg::RST_START;
			cfg_q.start_up  <= dss_pkg::RST_START_UP;
			cfg_q.top_cyl   <= dss_pkg::RST_TOP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dss_pkg::REG_MODE:     cfg_q.mode      <= cfg_data[dss_pkg::MODE_W-1:0];
				dss_pkg::REG_START:    cfg_q.start_cyl <= cfg_data[dss_pkg::CYL_W-1:0];
				dss_pkg::REG_START_UP: cfg_q.start_up  <= cfg_data[0];
				dss_pkg::REG_TOP:      cfg_q.top_cyl   <= cfg_data[dss_pkg::CYL_W-1:0];
				default:               cfg_q.mode      <= cfg_q.mode;
			endcase
		end
	end

	// front: clamp and queue requests
	dss_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cylinder     (cylinder),
		.last_request (last_request),
		.top_cyl      (cfg_q.top_cyl),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_pop        (q_pop)
	);

	// back: store the batch and run the scheduling pass
	dss_back #(
		.MAX_REQ (MAX_REQUESTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_pop       (q_pop),
		.cfg         (cfg_q),
		.res_strobe  (result_strobe),
		.res_visited (visited),
		.res_sum     (seek_total),
		.res_turn    (turn_count),
		.res_final   (final_step)
	);

	// the last result of a pass is never followed at once by another
	a_final_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && final_step |=> !result_strobe)
		else $error("result issued right after final step");

	// the queue only fills up after an accepted request
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// pop the queue only while it holds a request
	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule

/* tb/disk_seek_scheduler_checker.sv */
// ----------------------------------------------------------------------------
// disk_seek_scheduler_checker
// Watches the request, configuration and result channels of the disk seek
// scheduler, predicts the service order of each batch and compares results.
// ----------------------------------------------------------------------------
module disk_seek_scheduler_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [dss_pkg::CYL_W-1:0]      cylinder,
	input  logic                           last_request,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           result_strobe,
	input  logic [dss_pkg::CYL_W-1:0]      visited,
	input  logic [dss_pkg::SUM_W-1:0]      seek_total,
	input  logic                           turn_count,
	input  logic                           final_step,
	output int                             fail_count,
	output int                             pending_moves
);
	import dss_pkg::*;

	localparam int DEPTH = MAX_REQ_DEF;

	typedef struct packed {
		logic [CYL_W-1:0] cyl;
		logic [SUM_W-1:0] sum;
		logic             turn;
		logic             fin;
	} move_t;

	move_t            move_q[$];
	logic [MODE_W-1:0] cur_mode;
	logic [CYL_W-1:0] cur_start;
	logic             cur_up;
	logic [CYL_W-1:0] cur_top;
	logic [CYL_W-1:0] batch[DEPTH];
	int               batch_len;
	logic [CYL_W-1:0] arm;
	logic [SUM_W-1:0] seek_acc;
	logic             turned;

	assign pending_moves = move_q.size();

	function automatic void arm_move(logic [CYL_W-1:0] c);
		move_t m;
		seek_acc = seek_acc + ((c > arm) ? c - arm : arm - c);
		arm = c;
		m.cyl = c;
		m.sum = seek_acc;
		m.turn = turned;
		m.fin = 1'b0;
		move_q.push_back(m);
	endfunction

	task automatic schedule_batch();
		logic [CYL_W-1:0] srt[DEPTH];
		logic [CYL_W-1:0] v;
		bit done[DEPTH];
		int n, i, j, split, pick, first;
		int best;
		move_t m;
		n = batch_len;
		first = move_q.size();
		arm = cur_start;
		seek_acc = '0;
		turned = 1'b0;
		for (i = 0; i < DEPTH; i++) done[i] = 0;
		if (cur_mode == MODE_SSTF) begin
			for (j = 0; j < n; j++) begin
				pick = -1;
				best = 0;
				for (i = 0; i < n; i++)
					if (!done[i]) begin
						int d;
						d = int'((batch[i] > arm) ? batch[i] - arm : arm - batch[i]);
						if (pick < 0 || d < best) begin
							pick = i;
							best = d;
						end
					end
				done[pick] = 1;
				arm_move(batch[pick]);
			end
		end else if (cur_mode == MODE_SCAN || cur_mode == MODE_CSCAN
				|| cur_mode == MODE_LOOK) begin
			for (i = 0; i < n; i++) begin
				v = batch[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			split = 0;
			while (split < n && srt[split] < arm) split++;
			if (cur_mode == MODE_LOOK && !cur_up) begin
				for (i = split; i > 0; i--) arm_move(srt[i-1]);
				if (split < n) begin
					turned = 1'b1;
					for (i = split; i < n; i++) arm_move(srt[i]);
				end
			end else begin
				for (i = split; i < n; i++) arm_move(srt[i]);
				if (cur_mode == MODE_LOOK) begin
					if (split > 0) begin
						turned = 1'b1;
						for (i = split; i > 0; i--) arm_move(srt[i-1]);
					end
				end else begin
					if (arm < cur_top) arm_move(cur_top);
					turned = 1'b1;
					if (cur_mode == MODE_SCAN) begin
						for (i = split; i > 0; i--) arm_move(srt[i-1]);
						if (arm > 0) arm_move('0);
					end else begin
						arm_move('0);
						for (i = 0; i < split; i++) arm_move(srt[i]);
					end
				end
			end
		end else begin
			for (i = 0; i < n; i++) arm_move(batch[i]);
		end
		if (move_q.size() > first) begin
			m = move_q[$];
			m.fin = 1'b1;
			move_q[move_q.size()-1] = m;
		end
		batch_len = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [CYL_W-1:0] c;
		move_t e;
		if (!arst_n) begin
			cur_mode <= RST_MODE;
			cur_start <= RST_START;
			cur_up <= RST_START_UP;
			cur_top <= RST_TOP;
			batch_len = 0;
			fail_count <= 0;
			move_q.delete();
		end else begin
			if (result_strobe) begin
				if (move_q.size() == 0) begin
					$display("%0t: unexpected result visited=%0d sum=%0d", $time,
						visited, seek_total);
					fail_count <= fail_count + 1;
				end else begin
					e = move_q.pop_front();
					if (e.cyl !== visited || e.sum !== seek_total
							|| e.turn !== turn_count || e.fin !== final_step) begin
						$display("%0t: expected visited=%0d sum=%0d turn=%0b final=%0b, got visited=%0d sum=%0d turn=%0b final=%0b",
							$time, e.cyl, e.sum, e.turn, e.fin,
							visited, seek_total, turn_count, final_step);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:     cur_mode <= cfg_data[MODE_W-1:0];
					REG_START:    cur_start <= cfg_data[CYL_W-1:0];
					REG_START_UP: cur_up <= cfg_data[0];
					REG_TOP:      cur_top <= cfg_data[CYL_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				c = (cylinder > cur_top) ? cur_top : cylinder;
				if (batch_len < DEPTH) begin
					batch[batch_len] = c;
					batch_len++;
				end
				if (last_request) schedule_batch();
			end
		end
	end
endmodule

/* tb/disk_seek_scheduler_top_tb.sv */
// ----------------------------------------------------------------------------
// disk_seek_scheduler_top_tb
// Drives batches of cylinder requests and register settings into the disk
// seek scheduler; the checker predicts and compares every visited cylinder.
// ----------------------------------------------------------------------------
module disk_seek_scheduler_top_tb;
	import dss_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [CYL_W-1:0]      cylinder = '0;
	logic                  last_request = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  result_strobe;
	logic [CYL_W-1:0]      visited;
	logic [SUM_W-1:0]      seek_total;
	logic                  turn_count;
	logic                  final_step;
	int                    fail_count;
	int                    pending_moves;
	int                    sent;
	bit                    quiet;
	logic [CYL_W-1:0]      top_now;

	always #5 clk = ~clk;

	disk_seek_scheduler_top dut (.*);

	disk_seek_scheduler_checker chk (.*);

	// Hold off the sender for a random burst now and then, except near the end.
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Offer one request and hold it until the block takes it; start stays
	// high so the next request can follow at once.
	task automatic send_request(logic [CYL_W-1:0] c, logic fin);
		sender_gap();
		start <= 1'b1;
		cylinder <= c;
		last_request <= fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// Drop start, then drain every pending result.
	task automatic wait_idle();
		int guard;
		guard = 0;
		start <= 1'b0;
		@(posedge clk);
		while (pending_moves != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	// Hold valid high; the caller drops it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_TOP) top_now = val;
	endtask

	task automatic configure(logic [MODE_W-1:0] m, logic [CYL_W-1:0] s, logic up,
			logic [CYL_W-1:0] t);
		wait_idle();
		write_reg(REG_MODE, CFG_DATA_W'(m));
		write_reg(REG_START, s);
		write_reg(REG_START_UP, CFG_DATA_W'(up));
		write_reg(REG_TOP, t);
		cfg_valid <= 1'b0;
	endtask

	// Random batch: mostly within range, sometimes above top to hit the clamp.
	task automatic send_batch(int len);
		logic [CYL_W-1:0] c;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 5))
				0: c = CYL_W'($urandom);
				1: c = '0;
				default: c = CYL_W'($urandom_range(0, top_now));
			endcase
			send_request(c, i == len - 1);
		end
	endtask

	initial begin
		top_now = RST_TOP;
		sent = 0;
		quiet = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings in FCFS, field extremes, clamp.
		send_request(12'd0, 1'b0);
		send_request(12'hFFF, 1'b0);
		send_request(12'd99, 1'b0);
		send_request(12'd50, 1'b1);
		// Every mode over the same batch, plus the unused codes.
		for (int m = 0; m < 8; m++) begin
			configure(MODE_W'(m), 12'd53, m[0], 12'd199);
			send_request(12'd98, 1'b0);
			send_request(12'd183, 1'b0);
			send_request(12'd37, 1'b0);
			send_request(12'd122, 1'b0);
			send_request(12'd14, 1'b0);
			send_request(12'd124, 1'b0);
			send_request(12'd65, 1'b0);
			send_request(12'd67, 1'b1);
		end
		// SSTF tie: equal distance both sides, earliest loaded wins.
		configure(MODE_SSTF, 12'd100, 1'b1, 12'd4095);
		send_request(12'd110, 1'b0);
		send_request(12'd90, 1'b0);
		send_request(12'd90, 1'b1);
		// Start above top, zero top, and batch overflow.
		configure(MODE_SCAN, 12'd4095, 1'b0, 12'd10);
		send_request(12'd4095, 1'b0);
		send_request(12'd3, 1'b1);
		configure(MODE_CSCAN, 12'd0, 1'b1, 12'd0);
		send_request(12'd7, 1'b1);
		configure(MODE_LOOK, 12'd2048, 1'b0, 12'd4095);
		for (int i = 0; i < 19; i++) send_request(CYL_W'($urandom), i == 18);

		// Random phases; wait for all results before each new configuration.
		while (sent < 360) begin
			configure(MODE_W'($urandom_range(0, 7)),
				($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 1) * 4095)
					: 12'($urandom_range(0, 200)),
				1'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 1) ? 4095 : 1)
					: 12'($urandom_range(1, 200)));
			repeat ($urandom_range(1, 4)) begin
				send_batch(($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
					: $urandom_range(1, 8));
			end
			if (sent > 300) quiet = 1;
		end

		wait_idle();
		if (fail_count == 0 && pending_moves == 0)
			$display("disk_seek_scheduler_top: match");
		else
			$display("disk_seek_scheduler_top: mismatch");
		$finish;
	end

	initial begin
		#20000000;
		$display("disk_seek_scheduler_top: mismatch");
		$finish;
	end
endmodule

/* disk_seek_scheduler_top.f */
rtl/core/dss_pkg.sv
rtl/core/dss_ram.sv
rtl/core/dss_front.sv
rtl/core/dss_back.sv
rtl/core/disk_seek_scheduler_top.sv
tb/disk_seek_scheduler_checker.sv
tb/disk_seek_scheduler_top_tb.sv
